// ===== sv/contour_tracer_defines.svh =====
// Assertion macros for the contour tracer.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef CONTOUR_TRACER_DEFINES_SVH
`define CONTOUR_TRACER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CT_ASSERT_ALWAYS(lbl, expr, msg)
`define CT_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/ct_pkg.sv =====
// Shared constants and direction helpers for the contour tracer.
// No dependencies; used by ct_core and contour_tracer.
`timescale 1ns / 1ps

package ct_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_REPLY = 1'b1;

  localparam logic [1:0] CLS_OBJ = 2'd0;
  localparam logic [1:0] CLS_BG  = 2'd1;

  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_CLOSED   = 3'd1;
  localparam logic [2:0] ST_OPEN     = 3'd2;
  localparam logic [2:0] ST_NOT_OBJ  = 3'd3;
  localparam logic [2:0] ST_ENCLOSED = 3'd4;

  localparam logic [2:0] DIR_START = 3'd4;
  localparam logic [2:0] DIR_QUART = 3'd2;

  localparam logic [2:0] TURN_A_FWD = 3'd2;
  localparam logic [2:0] TURN_B_FWD = 3'd1;
  localparam logic [2:0] TURN_C_FWD = 3'd6;
  localparam logic [2:0] TURN_A_REV = 3'd6;
  localparam logic [2:0] TURN_B_REV = 3'd7;
  localparam logic [2:0] TURN_C_REV = 3'd2;

  function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0, 3'd1, 3'd7: r = 2'sd1;
      3'd3, 3'd4, 3'd5: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd5, 3'd6, 3'd7: r = 2'sd1;
      3'd1, 3'd2, 3'd3: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ct_in_reg.sv =====
// Input register stage of the contour tracer.
// Standalone; feeds ct_core.
`timescale 1ns / 1ps

module ct_in_reg #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_cmd,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic                         in_reverse_sense,
  input  logic [1:0]                   in_pixel_class,
  output logic                         item_valid,
  input  logic                         item_ready,
  output logic                         cmd,
  output logic signed [COORD_BITS-1:0] start_x,
  output logic signed [COORD_BITS-1:0] start_y,
  output logic                         reverse_sense,
  output logic [1:0]                   pixel_class
);

  assign in_tready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_tready) begin
      item_valid <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      cmd           <= in_cmd;
      start_x       <= in_start_x;
      start_y       <= in_start_y;
      reverse_sense <= in_reverse_sense;
      pixel_class   <= in_pixel_class;
    end
  end

endmodule

// ===== sv/ct_core.sv =====
// Trace state, single-pass step logic and result register of the contour tracer.
// Depends on ct_pkg.
`timescale 1ns / 1ps

module ct_core
  import ct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic                         reverse_sense,
  input  logic [1:0]                   pixel_class,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         probe_valid,
  output logic signed [COORD_BITS-1:0] probe_x,
  output logic signed [COORD_BITS-1:0] probe_y,
  output logic                         code_valid,
  output logic [2:0]                   chain_code,
  output logic                         done_res,
  output logic [2:0]                   status
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_SEARCH,
    PH_AHEAD,
    PH_DIAG_OBJ,
    PH_DIAG_UNK
  } phase_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  phase_t     phase, phase_next;
  coord_t     cur_x, cur_y, origin_x, origin_y;
  coord_t     cur_x_next, cur_y_next, origin_x_next, origin_y_next;
  logic [2:0] cur_dir, origin_dir, search_count;
  logic [2:0] cur_dir_next, origin_dir_next, search_count_next;
  logic       sense, sense_next;

  logic       pv, pstep, cv, dn, cont, closed, is_obj, is_bg, take;
  logic [2:0] pdir, cc, st, turn_a, turn_b, turn_c, k_b, k_a;
  coord_t     px, py;

  function automatic coord_t move(input coord_t v, input logic signed [1:0] d);
    return v + {{(COORD_BITS-2){d[1]}}, d};
  endfunction

  assign take       = item_valid && item_ready;
  assign item_ready = !res_valid || res_ready;
  assign is_obj     = pixel_class == CLS_OBJ;
  assign is_bg      = pixel_class == CLS_BG;
  assign turn_a     = sense ? TURN_A_REV : TURN_A_FWD;
  assign turn_b     = sense ? TURN_B_REV : TURN_B_FWD;
  assign turn_c     = sense ? TURN_C_REV : TURN_C_FWD;
  assign k_a        = cur_dir + turn_a;
  assign k_b        = cur_dir + turn_b;

  always_comb begin
    phase_next        = phase;
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    origin_x_next     = origin_x;
    origin_y_next     = origin_y;
    cur_dir_next      = cur_dir;
    origin_dir_next   = origin_dir;
    search_count_next = search_count;
    sense_next        = sense;
    pv                = 1'b0;
    pstep             = 1'b0;
    pdir              = '0;
    cv                = 1'b0;
    cc                = '0;
    dn                = 1'b0;
    st                = ST_RUNNING;
    cont              = 1'b0;
    if (cmd == CMD_START) begin
      origin_x_next = coord_t'(start_x);
      origin_y_next = coord_t'(start_y);
      cur_x_next    = coord_t'(start_x);
      cur_y_next    = coord_t'(start_y);
      sense_next    = reverse_sense;
      phase_next    = PH_START;
      pv            = 1'b1;
    end else begin
      unique case (phase)
        PH_START: begin
          if (!is_obj) begin
            phase_next = PH_IDLE;
            dn         = 1'b1;
            st         = ST_NOT_OBJ;
          end else begin
            search_count_next = '0;
            origin_dir_next   = DIR_START;
            phase_next        = PH_SEARCH;
            pv                = 1'b1;
            pstep             = 1'b1;
            pdir              = DIR_START;
          end
        end
        PH_SEARCH: begin
          if (is_bg) begin
            cur_dir_next = origin_dir;
            cur_x_next   = origin_x;
            cur_y_next   = origin_y;
            phase_next   = PH_AHEAD;
            pv           = 1'b1;
            pstep        = 1'b1;
            pdir         = origin_dir + turn_a;
          end else begin
            origin_dir_next   = origin_dir + DIR_QUART;
            search_count_next = search_count + 3'd1;
            if (search_count_next[2]) begin
              phase_next = PH_IDLE;
              dn         = 1'b1;
              st         = ST_ENCLOSED;
            end else begin
              pv    = 1'b1;
              pstep = 1'b1;
              pdir  = origin_dir_next;
            end
          end
        end
        PH_AHEAD: begin
          if (is_bg) begin
            cur_dir_next = k_a;
            cont         = 1'b1;
          end else begin
            phase_next = is_obj ? PH_DIAG_OBJ : PH_DIAG_UNK;
            pv         = 1'b1;
            pstep      = 1'b1;
            pdir       = k_b;
          end
        end
        PH_DIAG_OBJ, PH_DIAG_UNK: begin
          if (is_obj) begin
            cur_x_next   = move(cur_x, dir_dx(k_b));
            cur_y_next   = move(cur_y, dir_dy(k_b));
            cur_dir_next = cur_dir + turn_c;
            cv           = 1'b1;
            cc           = k_b;
            cont         = 1'b1;
          end else if (is_bg && phase == PH_DIAG_OBJ) begin
            cur_x_next = move(cur_x, dir_dx(k_a));
            cur_y_next = move(cur_y, dir_dy(k_a));
            cv         = 1'b1;
            cc         = k_a;
            cont       = 1'b1;
          end else begin
            phase_next = PH_IDLE;
            dn         = 1'b1;
            st         = ST_OPEN;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    closed = cur_x_next == origin_x_next && cur_y_next == origin_y_next &&
             cur_dir_next == origin_dir_next;
    if (cont) begin
      if (closed) begin
        phase_next = PH_IDLE;
        dn         = 1'b1;
        st         = ST_CLOSED;
      end else begin
        phase_next = PH_AHEAD;
        pv         = 1'b1;
        pstep      = 1'b1;
        pdir       = cur_dir_next + turn_a;
      end
    end

    px = pstep ? move(cur_x_next, dir_dx(pdir)) : cur_x_next;
    py = pstep ? move(cur_y_next, dir_dy(pdir)) : cur_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      cur_x        <= '0;
      cur_y        <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
      cur_dir      <= '0;
      origin_dir   <= DIR_START;
      sense        <= 1'b0;
      search_count <= '0;
      res_valid    <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      origin_x     <= origin_x_next;
      origin_y     <= origin_y_next;
      cur_dir      <= cur_dir_next;
      origin_dir   <= origin_dir_next;
      sense        <= sense_next;
      search_count <= search_count_next;
      res_valid    <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (take) begin
      probe_valid <= pv;
      probe_x     <= pv ? px : '0;
      probe_y     <= pv ? py : '0;
      code_valid  <= cv;
      chain_code  <= cc;
      done_res    <= dn;
      status      <= st;
    end
  end

endmodule

// ===== sv/contour_tracer.sv =====
// Top level of the contour tracer: input register, trace core, stream packing.
// Depends on ct_pkg, ct_in_reg, ct_core and contour_tracer_defines.svh.
//
// channel  dir  tdata (low bit up)                          tuser                  tlast
// s_*      in   start_x, start_y, reverse_sense, pixel_class cmd                    -
// m_*      out  probe_x, probe_y, chain_code, status         probe_valid,code_valid done_res
//
// One result transfer per input transfer; each passes the input register, then the result register.
// A new item is taken every cycle while the result side keeps up; the trace state loop
// closes through one pass of step logic.
// Reset (rst, synchronous) returns the trace to idle with origin direction four.
// A stall on m_tready holds the result and backs up into s_tready.
`timescale 1ns / 1ps
`include "contour_tracer_defines.svh"

module contour_tracer
  import ct_pkg::*;
#(
  parameter int  COORD_BITS = COORD_BITS_DEF,
  localparam int IN_USED    = 2 * COORD_BITS + 3,
  localparam int IN_W       = ((IN_USED + 7) / 8) * 8,
  localparam int OUT_USED   = 2 * COORD_BITS + 6,
  localparam int OUT_W      = ((OUT_USED + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // start_x, start_y, reverse_sense, pixel_class, zero fill
  input  logic [IN_W-1:0]      s_tdata,
  // cmd
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // probe_x, probe_y, chain_code, status, zero fill
  output logic [OUT_W-1:0]     m_tdata,
  // probe_valid, code_valid
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  localparam int RS_BIT   = 2 * COORD_BITS;
  localparam int CC_LSB   = 2 * COORD_BITS;
  localparam int ST_LSB   = 2 * COORD_BITS + 3;

  logic                         item_valid, item_ready;
  logic                         cmd, reverse_sense;
  logic signed [COORD_BITS-1:0] start_x, start_y;
  logic [1:0]                   pixel_class;
  logic                         probe_valid, code_valid, done_res;
  logic signed [COORD_BITS-1:0] probe_x, probe_y;
  logic [2:0]                   chain_code, status;

  ct_in_reg #(
    .COORD_BITS(COORD_BITS)
  ) u_in_reg (
    .clk             (clk),
    .rst             (rst),
    .in_tvalid       (s_tvalid),
    .in_tready       (s_tready),
    .in_cmd          (s_tuser),
    .in_start_x      (s_tdata[COORD_BITS-1:0]),
    .in_start_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_reverse_sense(s_tdata[RS_BIT]),
    .in_pixel_class  (s_tdata[RS_BIT+2:RS_BIT+1]),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .cmd             (cmd),
    .start_x         (start_x),
    .start_y         (start_y),
    .reverse_sense   (reverse_sense),
    .pixel_class     (pixel_class)
  );

  ct_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cmd          (cmd),
    .start_x      (start_x),
    .start_y      (start_y),
    .reverse_sense(reverse_sense),
    .pixel_class  (pixel_class),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .probe_valid  (probe_valid),
    .probe_x      (probe_x),
    .probe_y      (probe_y),
    .code_valid   (code_valid),
    .chain_code   (chain_code),
    .done_res     (done_res),
    .status       (status)
  );

  assign m_tdata = OUT_W'({status, chain_code, probe_y, probe_x});
  assign m_tuser = {code_valid, probe_valid};
  assign m_tlast = done_res;

  `CT_ASSERT_IMPLY(a_status_only_at_end, m_tvalid && !m_tlast, m_tdata[ST_LSB +: 3] == ST_RUNNING, "status set on a running step")
  `CT_ASSERT_IMPLY(a_no_probe_at_end, m_tvalid && m_tlast, !m_tuser[0], "probe requested with the final transfer")
  `CT_ASSERT_IMPLY(a_code_zero_when_unused, m_tvalid && !m_tuser[1], m_tdata[CC_LSB +: 3] == 3'd0, "chain code set without code_valid")
  `CT_ASSERT_IMPLY(a_backpressure, m_tvalid && !m_tready && item_valid, !s_tready, "input taken while both stages are full")

endmodule
